/* src/llms_pkg.sv */
// shared types and constants for the leaky lms adaptive filter
package llms_pkg;

  localparam int ORDER_DEF = 32;
  localparam int SAMPLE_W  = 16;
  localparam int WEIGHT_W  = 32;
  localparam int STEP_W    = 16;
  localparam int LEAK_W    = 17;
  localparam int POWER_W   = 48;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 17;

  localparam logic [STEP_W-1:0] STEP_RST = 16'd328;
  localparam logic [LEAK_W-1:0] LEAK_RST = 17'd65536;
  localparam int                EPS_Q30  = 1074;

  // normalised step divider: |mu*2^14*e*x| plus half the divisor, over power plus epsilon
  localparam int DVD_W = 61;
  localparam int DEN_W = POWER_W + 1;

  localparam logic [CFG_AW-1:0] REG_STEP_SIZE   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LEAK_FACTOR = 2'd1;
  localparam logic [CFG_AW-1:0] REG_NORM_MODE   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OLD_RD, ST_SQ, ST_PWR, ST_MAC_RD, ST_MAC_MUL, ST_MAC_ACC, ST_EST,
    ST_UPD_RD, ST_UPD_P1, ST_UPD_P2, ST_UPD_P3, ST_UPD_DIV, ST_UPD_WR, ST_DONE
  } llms_state_t;

  typedef struct packed {
    logic load_x;
    logic hist_rd;
    logic w_rd;
    logic sq;
    logic pwr;
    logic mac_mul;
    logic mac_acc;
    logic est;
    logic upd_p1;
    logic upd_p2;
    logic div_start;
    logic w_wr;
    logic out_load;
  } llms_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
    logic norm;
  } llms_sts_t;

endpackage

/* src/llms_if.sv */
// item channels of the filter: sample input and error result
interface llms_in_if import llms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface llms_out_if import llms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] error_out;
  modport source (output valid, output error_out, input ready);
  modport sink (input valid, input error_out, output ready);
endinterface

/* src/llms_ram.sv */
// generic single write port ram with registered read
module llms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* src/llms_div.sv */
// restoring divider, one quotient bit per cycle
module llms_div import llms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CW = $clog2(DVD_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DVD_W-1]};
    if (start) begin
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

/* src/llms_ctrl.sv */
// sequencer: power upkeep, estimate sweep and weight update sweep
module llms_ctrl import llms_pkg::*; #(
  parameter int ORDER = ORDER_DEF,
  localparam int AW = (ORDER > 1) ? $clog2(ORDER) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  input  llms_sts_t     sts,
  output llms_cmd_t     cmd,
  output logic [AW-1:0] hist_addr,
  output logic [AW-1:0] w_addr
);
  llms_state_t   state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [AW-1:0] tap_r, tap_nxt;
  logic          last_tap;
  logic [AW-1:0] slot_dec;

  assign last_tap = (tap_r == AW'(ORDER - 1));
  assign slot_dec = (slot_r == '0) ? AW'(ORDER - 1) : slot_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    slot_nxt  = slot_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_x = 1'b1;
          slot_nxt   = wp_r;
          tap_nxt    = '0;
          state_nxt  = ST_OLD_RD;
        end
      end
      ST_OLD_RD: begin
        cmd.hist_rd = 1'b1;
        state_nxt   = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_PWR;
      end
      ST_PWR: begin
        cmd.pwr   = 1'b1;
        state_nxt = ST_MAC_RD;
      end
      ST_MAC_RD: begin
        cmd.hist_rd = 1'b1;
        cmd.w_rd    = 1'b1;
        state_nxt   = ST_MAC_MUL;
      end
      ST_MAC_MUL: begin
        cmd.mac_mul = 1'b1;
        state_nxt   = ST_MAC_ACC;
      end
      ST_MAC_ACC: begin
        cmd.mac_acc = 1'b1;
        if (last_tap) begin
          state_nxt = ST_EST;
        end else begin
          tap_nxt   = tap_r + 1'b1;
          slot_nxt  = slot_dec;
          state_nxt = ST_MAC_RD;
        end
      end
      ST_EST: begin
        cmd.est   = 1'b1;
        tap_nxt   = '0;
        slot_nxt  = wp_r;
        state_nxt = ST_UPD_RD;
      end
      ST_UPD_RD: begin
        cmd.hist_rd = 1'b1;
        cmd.w_rd    = 1'b1;
        state_nxt   = ST_UPD_P1;
      end
      ST_UPD_P1: begin
        cmd.upd_p1 = 1'b1;
        state_nxt  = ST_UPD_P2;
      end
      ST_UPD_P2: begin
        cmd.upd_p2 = 1'b1;
        state_nxt  = ST_UPD_P3;
      end
      ST_UPD_P3: begin
        if (sts.norm) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_UPD_DIV;
        end else begin
          state_nxt = ST_UPD_WR;
        end
      end
      ST_UPD_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_UPD_WR;
        end
      end
      ST_UPD_WR: begin
        cmd.w_wr = 1'b1;
        if (last_tap) begin
          state_nxt = ST_DONE;
        end else begin
          tap_nxt   = tap_r + 1'b1;
          slot_nxt  = slot_dec;
          state_nxt = ST_UPD_RD;
        end
      end
      ST_DONE: begin
        if (!sts.out_full || out_ready) begin
          cmd.out_load = 1'b1;
          wp_nxt       = (wp_r == AW'(ORDER - 1)) ? '0 : wp_r + 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      slot_r  <= '0;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      slot_r  <= slot_nxt;
      tap_r   <= tap_nxt;
    end
  end

  assign hist_addr = slot_r;
  assign w_addr    = tap_r;
endmodule

/* src/llms_dp.sv */
// datapath: history and weight memories, shared mac, power, update arithmetic
module llms_dp import llms_pkg::*; #(
  parameter int ORDER = ORDER_DEF,
  localparam int AW = (ORDER > 1) ? $clog2(ORDER) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_AW-1:0]          cfg_addr,
  input  logic [CFG_DW-1:0]          cfg_wdata,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  llms_cmd_t                  cmd,
  input  logic [AW-1:0]              hist_addr,
  input  logic [AW-1:0]              w_addr,
  input  logic                       out_ready,
  output llms_sts_t                  sts,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_error
);
  localparam int ACC_W = 48 + $clog2(ORDER);

  logic [STEP_W-1:0] step_r;
  logic [LEAK_W-1:0] leak_r;
  logic              norm_r;

  logic signed [SAMPLE_W-1:0] x_r;
  logic [ORDER-1:0]           hist_vld_r, w_vld_r;
  logic                       hist_vq_r, w_vq_r;
  logic [SAMPLE_W-1:0]        hist_rdata;
  logic [WEIGHT_W-1:0]        w_rdata;
  logic signed [SAMPLE_W-1:0] tap;
  logic signed [WEIGHT_W-1:0] wgt;

  logic [31:0]          old_sq_r, new_sq_r;
  logic [POWER_W-1:0]   power_r, power_sub;
  // full-scale negative weight times full-scale negative tap needs all 48 bits
  logic signed [47:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SAMPLE_W-1:0] err_r;
  logic signed [49:0]   lp_r;
  logic signed [31:0]   et_r;
  logic signed [33:0]   leaked_r;
  logic signed [47:0]   mt_r;
  logic                 neg_r;
  logic                 out_valid_r;
  logic signed [SAMPLE_W-1:0] out_err_r;

  logic signed [31:0]   sq_old, sq_new;
  logic signed [47:0]   prod_c;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-31:0] est;
  logic signed [ACC_W-30:0] diff;
  logic signed [SAMPLE_W-1:0] err_c;
  logic signed [49:0]   lp_c, lrnd;
  logic signed [31:0]   et_c;
  logic signed [48:0]   mt_c;
  logic signed [47:0]   mrnd, mneg;
  logic [46:0]          mag;
  logic [DEN_W-1:0]     den;
  logic [DVD_W-1:0]     dividend, quotient;
  logic signed [61:0]   nterm;
  logic signed [62:0]   wsum;
  logic signed [WEIGHT_W-1:0] new_w;
  logic                 div_done;

  llms_ram #(.WIDTH(SAMPLE_W), .DEPTH(ORDER)) u_hist (
    .clk(clk), .we(cmd.pwr), .waddr(hist_addr), .wdata(x_r),
    .re(cmd.hist_rd), .raddr(hist_addr), .rdata(hist_rdata)
  );

  llms_ram #(.WIDTH(WEIGHT_W), .DEPTH(ORDER)) u_wgt (
    .clk(clk), .we(cmd.w_wr), .waddr(w_addr), .wdata(new_w),
    .re(cmd.w_rd), .raddr(w_addr), .rdata(w_rdata)
  );

  llms_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dividend),
    .divisor(den), .done(div_done), .quotient(quotient)
  );

  // entries never written since reset read as zero
  assign tap = hist_vq_r ? $signed(hist_rdata) : '0;
  assign wgt = w_vq_r ? $signed(w_rdata) : '0;

  always_comb begin
    sq_old    = tap * tap;
    sq_new    = x_r * x_r;
    power_sub = (power_r >= POWER_W'(old_sq_r)) ? power_r - POWER_W'(old_sq_r) : '0;
    prod_c    = wgt * tap;
    rnd       = acc_r + ACC_W'(1 << 29);
    est       = rnd[ACC_W-1:30];
    diff      = $signed({{(ACC_W-29-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r})
                - $signed({est[ACC_W-31], est});
    if (diff > (ACC_W-29)'(32767)) begin
      err_c = 16'sh7fff;
    end else if (diff < -$signed((ACC_W-29)'(32768))) begin
      err_c = -16'sh8000;
    end else begin
      err_c = diff[SAMPLE_W-1:0];
    end
    lp_c  = wgt * $signed({1'b0, leak_r});
    et_c  = err_r * tap;
    mt_c  = $signed({1'b0, step_r}) * et_r;
    lrnd  = lp_r + 50'sd32768;
    mrnd  = mt_r + 48'sd32768;
    mneg  = -mt_r;
    mag   = mt_r[47] ? mneg[46:0] : mt_r[46:0];
    den   = {1'b0, power_r} + DEN_W'(EPS_Q30);
    dividend = {mag, 14'b0} + DVD_W'(den[DEN_W-1:1]);
    nterm = neg_r ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    if (norm_r) begin
      wsum = $signed({{29{leaked_r[33]}}, leaked_r}) + $signed({nterm[61], nterm});
    end else begin
      wsum = $signed({{29{leaked_r[33]}}, leaked_r})
             + $signed({{31{mrnd[47]}}, mrnd[47:16]});
    end
    if (wsum > 63'sh7fffffff) begin
      new_w = 32'sh7fffffff;
    end else if (wsum < -63'sh80000000) begin
      new_w = -32'sh80000000;
    end else begin
      new_w = wsum[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RST;
      leak_r      <= LEAK_RST;
      norm_r      <= 1'b0;
      hist_vld_r  <= '0;
      w_vld_r     <= '0;
      power_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_STEP_SIZE:   step_r <= cfg_wdata[STEP_W-1:0];
          REG_LEAK_FACTOR: leak_r <= cfg_wdata[LEAK_W-1:0];
          REG_NORM_MODE:   norm_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.pwr) begin
        hist_vld_r[hist_addr] <= 1'b1;
        power_r <= power_sub + POWER_W'(new_sq_r);
      end
      if (cmd.w_wr) begin
        w_vld_r[w_addr] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.load_x) x_r <= sample;
    if (cmd.hist_rd) hist_vq_r <= hist_vld_r[hist_addr];
    if (cmd.w_rd) w_vq_r <= w_vld_r[w_addr];
    if (cmd.sq) begin
      old_sq_r <= sq_old;
      new_sq_r <= sq_new;
    end
    if (cmd.pwr) acc_r <= '0;
    if (cmd.mac_mul) prod_r <= prod_c;
    if (cmd.mac_acc) acc_r <= acc_r + ACC_W'(prod_r);
    if (cmd.est) err_r <= err_c;
    if (cmd.upd_p1) begin
      lp_r <= lp_c;
      et_r <= et_c;
    end
    if (cmd.upd_p2) begin
      leaked_r <= lrnd[49:16];
      mt_r     <= mt_c[47:0];
    end
    if (cmd.div_start) neg_r <= mt_r[47];
    if (cmd.out_load) out_err_r <= err_r;
  end

  assign sts.div_done = div_done;
  assign sts.out_full = out_valid_r;
  assign sts.norm     = norm_r;
  assign out_valid    = out_valid_r;
  assign out_error    = out_err_r;
endmodule

/* src/leaky_lms_adaptive_filter.sv */
// leaky (n)lms adaptive prediction filter, top level
//
// in_if carries one signed q1.15 sample per item; out_if returns one
// saturated q1.15 prediction error per item. registers are written through
// cfg_we / cfg_addr / cfg_wdata: step size, leak factor, normalise mode.
// items are handled one at a time: power upkeep (read the oldest sample,
// square old and new, update power), estimate sweep (read, multiply,
// accumulate per tap), then weight update sweep (read, leak and step
// products, rounding, bit-serial divide in normalised mode, write per tap).
// a new item is taken only after the last result has been loaded.
// the result sits in an output register, so a stalled receiver only holds
// the next result back once its own sweeps are finished; in_if.ready is
// high whenever no item is in flight.
// reset clears history, weights (per entry valid bits), power, ring
// pointer and loads register defaults; no clearing pass is needed.
module leaky_lms_adaptive_filter import llms_pkg::*; #(
  parameter int ORDER = ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  llms_in_if.sink           in_if,
  llms_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);
  localparam int AW = (ORDER > 1) ? $clog2(ORDER) : 1;

  llms_cmd_t     cmd;
  llms_sts_t     sts;
  logic [AW-1:0] hist_addr, w_addr;

  llms_ctrl #(.ORDER(ORDER)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_ready(out_if.ready), .sts(sts), .cmd(cmd),
    .hist_addr(hist_addr), .w_addr(w_addr)
  );

  llms_dp #(.ORDER(ORDER)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .sample(in_if.sample_in), .cmd(cmd),
    .hist_addr(hist_addr), .w_addr(w_addr), .out_ready(out_if.ready),
    .sts(sts), .out_valid(out_if.valid), .out_error(out_if.error_out)
  );
endmodule

/* src/llms_chk.sv */
// port level checks for the filter top, bound in below
module llms_chk import llms_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] error_out
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(error_out))
    else $error("result dropped or changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result shown before any work was done");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind leaky_lms_adaptive_filter llms_chk u_llms_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .error_out(out_if.error_out)
);
